[design/histeq_pkg.sv]
`timescale 1ns / 1ps
package histeq_pkg;
  localparam int MAX_PIXELS_LOG2 = 20;
  localparam int LEVELS = 256;
  localparam int CW = MAX_PIXELS_LOG2 + 1;
  localparam int AW = $clog2(LEVELS);
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
  localparam logic [1:0] ACT_COUNT = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_MAP = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;
endpackage

[design/histeq_ram.sv]
`timescale 1ns / 1ps
module histeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[design/histogram_equalizer.sv]
`timescale 1ns / 1ps
// channel | ports                                   | dir
// input   | start, in_action, in_pixel (busy is out)    | in
// result  | out_valid, out_mapped_level, out_clipped, out_slope_fault | out
// config  | cfg_we, cfg_data                        | in
// after reset a clearing pass zeroes all 256 bins while busy
// count: read, modify, write of the bin (states S_CRD, S_CWR)
// clear: one bin a cycle through the single ram write port
// finish: walks the bins into running sums, fetches the top sum, then a 21-step divide (skipped if top 0)
// map: reads the sum, then a 21-step restoring divide; the divide is skipped when the slope is unusable
// results are strobed for one cycle; the receiver cannot stall
module histogram_equalizer
  import histeq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_action,
  input  logic [7:0] in_pixel,
  output logic       out_valid,
  output logic [7:0] out_mapped_level,
  output logic       out_clipped,
  output logic       out_slope_fault,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);
  typedef enum logic [8:0] {
    S_CLR = 9'b000000001, S_IDLE = 9'b000000010, S_CRD = 9'b000000100,
    S_CWR = 9'b000001000, S_FRD = 9'b000010000, S_FACC = 9'b000100000,
    S_MRD = 9'b001000000, S_DIV = 9'b010000000, S_MWT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0]    top_r;
  logic [7:0]    pix_r, pix_nxt;
  logic [AW:0]   idx_r, idx_nxt;     // sweep counter, one extra bit for the end
  logic [CW-1:0] run_r, run_nxt;
  logic [CW-1:0] slope_r, slope_nxt;
  logic          fin_r, fin_nxt;
  logic          dfin_r, dfin_nxt;   // divide belongs to finish, not map
  // shared restoring divider
  logic [CW-1:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [4:0]    step_r, step_nxt;
  logic          ov_r, ov_nxt, cl_r, cl_nxt, sf_r, sf_nxt;

  // ram ports
  logic          bin_we, cum_we;
  logic [AW-1:0] bin_wa, bin_ra, cum_ra;
  logic [CW-1:0] bin_wd, bin_rd, cum_rd;

  histeq_ram #(.WIDTH(CW), .DEPTH(LEVELS)) u_bins (
    .clk, .we(bin_we), .waddr(bin_wa), .wdata(bin_wd), .raddr(bin_ra), .rdata(bin_rd));
  histeq_ram #(.WIDTH(CW), .DEPTH(LEVELS)) u_cums (
    .clk, .we(cum_we), .waddr(idx_r[AW-1:0] - AW'(1)), .wdata(run_nxt),
    .raddr(cum_ra), .rdata(cum_rd));

  logic [CW:0]   trial;
  logic [CW-1:0] sum_w;
  logic [CW:0]   sum_full;

  always_comb begin
    state_nxt = state_r; pix_nxt = pix_r; idx_nxt = idx_r; run_nxt = run_r;
    slope_nxt = slope_r; fin_nxt = fin_r; dfin_nxt = dfin_r;
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r; step_nxt = step_r;
    ov_nxt = 1'b0; cl_nxt = cl_r; sf_nxt = sf_r;
    bin_we = 1'b0; bin_wa = pix_r; bin_wd = '0; bin_ra = pix_r;
    cum_we = 1'b0; cum_ra = pix_r;
    trial = {rem_r, quo_r[CW-1]} - {1'b0, dvs_r};
    sum_full = {1'b0, run_r} + {1'b0, bin_rd};
    sum_w = sum_full[CW] ? COUNT_MAX : sum_full[CW-1:0];
    case (state_r)
      S_CLR: begin
        // zero one bin a cycle
        bin_we = 1'b1; bin_wa = idx_r[AW-1:0]; bin_wd = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (AW+1)'(LEVELS-1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        idx_nxt = '0;
        if (start) begin
          pix_nxt = in_pixel;
          case (in_action)
            ACT_COUNT: state_nxt = S_CRD;
            ACT_FINISH: begin
              run_nxt = '0; state_nxt = S_FRD;
              bin_ra = '0;
            end
            ACT_MAP: state_nxt = S_MRD;
            default: begin
              fin_nxt = 1'b0; state_nxt = S_CLR;
            end
          endcase
        end
      end
      S_CRD: state_nxt = S_CWR;   // ram read latency
      S_CWR: begin
        bin_we = (bin_rd != COUNT_MAX);
        bin_wd = bin_rd + CW'(1);
        state_nxt = S_IDLE;
      end
      S_FRD: begin
        // prime read of bin idx
        bin_ra = idx_r[AW-1:0];
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_FACC;
      end
      S_FACC: begin
        // bin_rd is bin idx-1; accumulate and store, read next
        run_nxt = sum_w;
        cum_we = 1'b1;
        bin_ra = idx_r[AW-1:0];
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (AW+1)'(LEVELS)) begin
          cum_ra = top_r; state_nxt = S_MRD; dfin_nxt = 1'b1;
        end
      end
      S_MRD: begin
        // cum_rd valid next cycle, in S_MWT, which sets up the divider
        cum_ra = dfin_r ? top_r : pix_r;
        state_nxt = S_MWT;
      end
      S_MWT: begin
        quo_nxt = cum_rd; rem_nxt = '0; step_nxt = '0;
        dvs_nxt = dfin_r ? CW'(top_r) : slope_r;
        if (dfin_r && top_r == 8'd0) begin
          slope_nxt = '0; fin_nxt = 1'b1; dfin_nxt = 1'b0; state_nxt = S_IDLE;
        end else if (!dfin_r && (!fin_r || slope_r == '0)) begin
          ov_nxt = 1'b1; cl_nxt = 1'b0; sf_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else state_nxt = S_DIV;
      end
      S_DIV: begin
        // one quotient bit a cycle
        if (!trial[CW]) begin
          rem_nxt = trial[CW-1:0]; quo_nxt = {quo_r[CW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[CW-2:0], quo_r[CW-1]}; quo_nxt = {quo_r[CW-2:0], 1'b0};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(CW-1)) begin
          state_nxt = S_IDLE;
          if (dfin_r) begin
            slope_nxt = quo_nxt; fin_nxt = 1'b1; dfin_nxt = 1'b0;
          end else begin
            ov_nxt = 1'b1; sf_nxt = 1'b0;
            cl_nxt = (quo_nxt > CW'(255));
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [7:0] lvl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; idx_r <= '0; fin_r <= 1'b0; dfin_r <= 1'b0;
      slope_r <= '0; top_r <= 8'd255; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; fin_r <= fin_nxt; dfin_r <= dfin_nxt;
      slope_r <= slope_nxt; ov_r <= ov_nxt;
      if (cfg_we) top_r <= cfg_data;
    end
    pix_r <= pix_nxt; run_r <= run_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt;
    dvs_r <= dvs_nxt; step_r <= step_nxt; cl_r <= cl_nxt;
    sf_r <= sf_nxt;
    lvl_r <= (sf_nxt || cl_nxt) ? 8'd255 : quo_nxt[7:0];
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_mapped_level = lvl_r;
  assign out_clipped = cl_r;
  assign out_slope_fault = sf_r;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_clipped && out_slope_fault)) else $error("both flags");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> out_mapped_level == 8'd255) else $error("clip value");
`endif
endmodule

[tb/sv/histogram_equalizer_tb.sv]
`timescale 1ns / 1ps
module histogram_equalizer_tb;
  import histeq_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_action;
  logic [7:0] in_pixel;
  logic       out_valid;
  logic [7:0] out_mapped_level;
  logic       out_clipped;
  logic       out_slope_fault;
  logic       cfg_we;
  logic [7:0] cfg_data;

  histogram_equalizer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_mapped_level(out_mapped_level),
    .out_clipped(out_clipped), .out_slope_fault(out_slope_fault),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // one expected map result
  typedef struct packed {
    logic [7:0] level;
    logic       clip;
    logic       fault;
  } map_result_t;

  // directed request, with an optional typed-in expectation
  typedef struct {
    logic [1:0]  act;
    logic [7:0]  pix;
    bit          known;
    map_result_t res;
  } request_row_t;

  // shadow copy of the block state
  logic [CW-1:0] model_bins [LEVELS];
  logic [CW-1:0] model_cdf [LEVELS];
  logic [CW-1:0] model_slope;
  logic          model_done;
  logic [7:0]    model_top;

  map_result_t expected_maps[$];
  int          fail_count;
  int          map_seen;
  int          req_sent;
  int          clip_seen;
  int          fault_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous time limit on the whole run; reaching it reports a fail
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // model of one accepted request; returns the map result if any
  function automatic bit equalize_step(input logic [1:0] act, input logic [7:0] pix,
                                       output map_result_t res);
    logic [CW:0]   run;
    logic [CW-1:0] quo;
    res = '0;
    case (act)
      ACT_COUNT: begin
        if (model_bins[pix] != COUNT_MAX) model_bins[pix] = model_bins[pix] + 1'b1;
        return 0;
      end
      ACT_FINISH: begin
        run = '0;
        for (int i = 0; i < LEVELS; i++) begin
          run = run + model_bins[i];
          if (run > COUNT_MAX) run = COUNT_MAX;
          model_cdf[i] = run[CW-1:0];
        end
        // top level zero means no usable slope
        model_slope = (model_top == 0) ? '0 : model_cdf[model_top] / model_top;
        model_done = 1'b1;
        return 0;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < LEVELS; i++) model_bins[i] = '0;
        model_done = 1'b0;
        return 0;
      end
      default: begin
        if (!model_done || model_slope == 0) begin
          res = '{8'd255, 1'b0, 1'b1};
        end else begin
          quo = model_cdf[pix] / model_slope;
          if (quo > 255) res = '{8'd255, 1'b1, 1'b0};
          else res = '{quo[7:0], 1'b0, 1'b0};
        end
        return 1;
      end
    endcase
  endfunction

  // result checker: results are strobed, so sample on every edge
  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_valid) begin
      map_seen++;
      if (expected_maps.size() == 0) begin
        report_mismatch("unexpected result, level", out_mapped_level, -1);
      end else begin
        want = expected_maps.pop_front();
        if (out_mapped_level !== want.level)
          report_mismatch("mapped_level", out_mapped_level, want.level);
        if (out_clipped !== want.clip) report_mismatch("clipped", out_clipped, want.clip);
        if (out_slope_fault !== want.fault)
          report_mismatch("slope_fault", out_slope_fault, want.fault);
        clip_seen += want.clip;
        fault_seen += want.fault;
      end
    end
  end

  // random gap: mostly short, a few long
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  // send one request and wait for acceptance (start high, busy low)
  task automatic send_request(input logic [1:0] act, input logic [7:0] pix,
                              input bit known, input map_result_t typed);
    map_result_t res;
    bit has;
    start <= 1'b1;
    in_action <= act;
    in_pixel <= pix;
    do @(posedge clk); while (busy);
    has = equalize_step(act, pix, res);
    if (has) begin
      // a typed row must agree with the predictor as well
      if (known && res !== typed) report_mismatch("typed row vs predictor", typed, res);
      expected_maps.push_back(res);
    end
    req_sent++;
    start <= 1'b0;
    in_action <= 2'($urandom_range(0, 3));
    in_pixel <= 8'($urandom_range(0, 255));
    // the block is busy for at least this cycle after any accepted request
    @(posedge clk);
  endtask

  // wait for all results, then let a clear/finish run out before config
  task automatic drain();
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_top(input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    model_top = value;
    cfg_we <= 1'b0;
  endtask

  // random phase: a clear, counts, a finish (skipped one time in eight), then mostly maps
  task automatic random_frame(input int n_count, input int n_map);
    int r;
    logic [7:0] hot;
    hot = 8'($urandom_range(0, 255));
    send_request(ACT_CLEAR, 8'($urandom_range(0, 255)), 0, '0);
    for (int i = 0; i < n_count; i++) begin
      idle_gap();
      r = $urandom_range(0, 9);
      // skewed pixels make some bins large and quotients clip
      send_request(ACT_COUNT, (r < 4) ? hot : 8'($urandom_range(0, 255)), 0, '0);
    end
    if ($urandom_range(0, 7) != 0)
      send_request(ACT_FINISH, 8'($urandom_range(0, 255)), 0, '0);
    for (int i = 0; i < n_map; i++) begin
      idle_gap();
      r = $urandom_range(0, 19);
      if (r == 0) send_request(ACT_COUNT, 8'($urandom_range(0, 255)), 0, '0);
      else if (r == 1) send_request(ACT_FINISH, 8'($urandom_range(0, 255)), 0, '0);
      else send_request(ACT_MAP, 8'($urandom_range(0, 255)), 0, '0);
    end
  endtask

  request_row_t directed[$];

  initial begin
    logic [7:0] tops[6];
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_COUNT;
    in_pixel = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    map_seen = 0;
    req_sent = 0;
    clip_seen = 0;
    fault_seen = 0;
    for (int i = 0; i < LEVELS; i++) begin
      model_bins[i] = '0;
      model_cdf[i] = '0;
    end
    model_slope = '0;
    model_done = 1'b0;
    model_top = 8'd255;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: map before finish faults, extremes of pixel, every action
    directed = '{
      '{ACT_MAP,    8'd0,   1, '{8'd255, 1'b0, 1'b1}},
      '{ACT_MAP,    8'd255, 1, '{8'd255, 1'b0, 1'b1}},
      '{ACT_COUNT,  8'd0,   0, '0},
      '{ACT_COUNT,  8'd255, 0, '0},
      '{ACT_COUNT,  8'd128, 0, '0},
      '{ACT_FINISH, 8'd0,   0, '0},
      // cumulative at 255 is 3, slope 3/255 is zero: fault
      '{ACT_MAP,    8'd0,   1, '{8'd255, 1'b0, 1'b1}},
      '{ACT_CLEAR,  8'd0,   0, '0},
      '{ACT_MAP,    8'd7,   1, '{8'd255, 1'b0, 1'b1}},
      '{ACT_COUNT,  8'd170, 0, '0},
      '{ACT_COUNT,  8'd85,  0, '0}
    };
    foreach (directed[i]) begin
      idle_gap();
      send_request(directed[i].act, directed[i].pix, directed[i].known, directed[i].res);
    end
    drain();

    // low top level so slope is nonzero: real quotients
    write_top(8'd1);
    send_request(ACT_COUNT, 8'd0, 0, '0);
    send_request(ACT_FINISH, 8'd0, 0, '0);
    send_request(ACT_MAP, 8'd0, 0, '0);
    send_request(ACT_MAP, 8'd255, 0, '0);
    // count after finish leaves the sums alone
    send_request(ACT_COUNT, 8'd0, 0, '0);
    send_request(ACT_MAP, 8'd200, 0, '0);
    drain();
    // top level zero: slope taken as zero
    write_top(8'd0);
    send_request(ACT_FINISH, 8'd0, 0, '0);
    send_request(ACT_MAP, 8'd255, 1, '{8'd255, 1'b0, 1'b1});
    drain();

    // random phases across several top levels, extremes included
    tops = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd128, 8'd16};
    for (int phase = 0; phase < 38; phase++) begin
      write_top((phase < 6) ? tops[phase] : 8'($urandom_range(0, 255)));
      random_frame($urandom_range(5, 40), $urandom_range(5, 30));
      drain();
    end

    $display("covered %0d requests, %0d map results (%0d clipped, %0d faulted)",
             req_sent, map_seen, clip_seen, fault_seen);
    $display("top levels 0, 1, 255 and random, with clears, refinish and late counts");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
